// ===== design/damage_rectangle_tracker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// damage rectangle tracker assertion macros
// shared assertion forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef DAMAGE_RECTANGLE_TRACKER_UNIT_MACROS_SVH
`define DAMAGE_RECTANGLE_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define DRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg
// types, constants and rectangle helpers of the damage rectangle tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package drt_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam logic signed [15:0] SAT_HI = 16'sh7FFF;
	localparam logic signed [15:0] SAT_LO = -16'sh8000;
	localparam logic signed [32:0] BEST_INIT = 33'sd2147483647;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_CLEAR = 3'd1;
	localparam logic [2:0] OP_CLIP  = 3'd2;
	localparam logic [2:0] OP_BBOX  = 3'd3;
	localparam logic [2:0] OP_LIST  = 3'd4;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
	} box_t;

	function automatic logic is_empty(box_t r);
		return (r.w <= 16'sd0) || (r.h <= 16'sd0);
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [17:0] v);
		if (v < 18'(SAT_LO)) return SAT_LO;
		if (v > 18'(SAT_HI)) return SAT_HI;
		return 16'(v);
	endfunction

	function automatic logic signed [16:0] right_of(box_t r);
		return 17'(r.x) + 17'(r.w);
	endfunction

	function automatic logic signed [16:0] bottom_of(box_t r);
		return 17'(r.y) + 17'(r.h);
	endfunction

	function automatic box_t make_box(logic signed [15:0] x1, logic signed [15:0] y1,
		logic signed [16:0] x2, logic signed [16:0] y2);
		box_t r;
		r.x = x1;
		r.y = y1;
		r.w = sat16(18'(x2) - 18'(x1));
		r.h = sat16(18'(y2) - 18'(y1));
		return r;
	endfunction

	function automatic box_t union_box(box_t a, box_t b);
		logic signed [15:0] x1, y1;
		logic signed [16:0] x2, y2;
		x1 = (a.x < b.x) ? a.x : b.x;
		y1 = (a.y < b.y) ? a.y : b.y;
		x2 = (right_of(a) > right_of(b)) ? right_of(a) : right_of(b);
		y2 = (bottom_of(a) > bottom_of(b)) ? bottom_of(a) : bottom_of(b);
		if (is_empty(a)) return is_empty(b) ? box_t'('0) : b;
		if (is_empty(b)) return a;
		return make_box(x1, y1, x2, y2);
	endfunction

	function automatic box_t clip_box(box_t a, box_t b);
		logic signed [15:0] x1, y1;
		logic signed [16:0] x2, y2;
		x1 = (a.x > b.x) ? a.x : b.x;
		y1 = (a.y > b.y) ? a.y : b.y;
		x2 = (right_of(a) < right_of(b)) ? right_of(a) : right_of(b);
		y2 = (bottom_of(a) < bottom_of(b)) ? bottom_of(a) : bottom_of(b);
		if (is_empty(a) || is_empty(b)) return '0;
		if ((x2 <= 17'(x1)) || (y2 <= 17'(y1))) return '0;
		return make_box(x1, y1, x2, y2);
	endfunction

	// a covers b
	function automatic logic covers(box_t a, box_t b);
		if (is_empty(b)) return 1'b1;
		if (is_empty(a)) return 1'b0;
		return (b.x >= a.x) && (b.y >= a.y) && (right_of(b) <= right_of(a)) &&
			(bottom_of(b) <= bottom_of(a));
	endfunction

endpackage

// ===== design/damage_rectangle_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// damage_rectangle_tracker_unit
// bounded list of damaged rectangles with add/merge, clear, clip, bounding
// box and readout, held in a one-port-read one-port-write table memory
// ----------------------------------------------------------------------------
// channel | direction | handshake           | word
// input   | in        | in_valid / in_stall | operation, rect_x, rect_y, rect_w, rect_h
// output  | out       | out_valid/out_stall | out_x, out_y, out_w, out_h, entry_total,
//         |           |                     | last_result
//
// one word is taken at a time; in_stall is high from acceptance until the last
// result has been loaded into the output register
// clear and unknown codes go straight to the emit state; clip, bounding box and
// list walk the held entries; an add walks them in each merge round and, with a
// full table, scores the newcomer against every entry and every pair of entries
// the run time is set by the single table read port and the shared 15x15 area
// multiplier (four areas per waste score)
// arst_n clears the count, sequencer and out_valid; table contents need no reset
// a stalled output holds the sequencer in its emit state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module damage_rectangle_tracker_unit
	import drt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic signed [15:0] rect_w,
	input  logic signed [15:0] rect_h,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_w,
	output logic signed [15:0] out_h,
	output logic [3:0]         entry_total,
	output logic               last_result
);

	typedef enum logic [5:0] {
		ST_IDLE, ST_DISPATCH, ST_EMIT,
		ST_COV_RD, ST_COV_CHK,
		ST_RM_RD, ST_RM_CHK, ST_RM_MOVE,
		ST_MG_RD, ST_MG_LD, ST_MG_CHK, ST_MG_MOVE,
		ST_APPEND,
		ST_FL_RD_I, ST_FL_LD_I, ST_FL_CHK_N, ST_FL_RD_J, ST_FL_LD_J, ST_FL_CHK_P,
		ST_FL_FIN, ST_FL_U1, ST_FL_U2, ST_FL_U3, ST_FL_U4, ST_FL_U5,
		ST_W_PREP, ST_W_MUL, ST_W_ACC,
		ST_CL_RD, ST_CL_CHK,
		ST_BB_RD, ST_BB_CHK,
		ST_LS_RD, ST_LS_LD
	} state_t;

	// table memory
	box_t             mem [MAX_ENTRIES];
	box_t             rd_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	box_t             wr_data;

	// sequencer state
	state_t           state_q, ret_q;
	logic [2:0]       op_q;
	box_t             r_q;       // newcomer or clip bounds
	logic [CNT_W-1:0] cnt_q, i_q, j_q, n_q;
	logic [IDX_W-1:0] bi_q, bj_q;
	logic             with_new_q;
	logic signed [32:0] best_q;
	box_t             a_q, b_q;  // waste operands
	box_t             u_q, c_q;  // their union and overlap
	logic [1:0]       k_q;
	logic [29:0]      prod_q;
	logic signed [32:0] acc_q;
	box_t             bb_q;
	box_t             eb_q;      // box to emit
	logic             el_q;      // emit carries the final flag

	// output register
	logic             out_valid_q;
	box_t             out_box_q;
	logic [3:0]       out_total_q;
	logic             out_last_q;

	logic             out_free;
	logic [CNT_W-1:0] cnt_m1, i_nxt, j_nxt;
	box_t             msel, clip_rd, un_new;
	logic [29:0]      area_sel;

	assign out_free = !out_valid_q || !out_stall;
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign i_nxt    = i_q + CNT_W'(1);
	assign j_nxt    = j_q + CNT_W'(1);
	assign clip_rd  = clip_box(rd_q, r_q);
	assign un_new   = union_box(rd_q, r_q);

	// area of union, a, b, overlap in turn
	always_comb begin
		case (k_q)
			2'd0:    msel = u_q;
			2'd1:    msel = a_q;
			2'd2:    msel = b_q;
			default: msel = c_q;
		endcase
		area_sel = is_empty(msel) ? 30'd0 : (30'(msel.w[14:0]) * 30'(msel.h[14:0]));
	end

	// table port requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = i_q[IDX_W-1:0];
		wr_data = rd_q;
		unique case (state_q)
			ST_COV_RD, ST_RM_RD, ST_MG_RD, ST_FL_RD_I, ST_CL_RD, ST_BB_RD:
				rd_en = (i_q != cnt_q);
			ST_LS_RD: rd_en = 1'b1;
			ST_RM_CHK: begin
				rd_en   = covers(r_q, rd_q);
				rd_addr = cnt_m1[IDX_W-1:0];
			end
			ST_MG_CHK: begin
				rd_en   = (acc_q <= 33'sd0);
				rd_addr = cnt_m1[IDX_W-1:0];
			end
			ST_RM_MOVE, ST_MG_MOVE: wr_en = 1'b1;
			ST_APPEND: begin
				wr_en   = (cnt_q < CNT_W'(MAX_ENTRIES));
				wr_addr = cnt_q[IDX_W-1:0];
				wr_data = r_q;
			end
			ST_FL_RD_J: begin
				rd_en   = (j_q != cnt_q);
				rd_addr = j_q[IDX_W-1:0];
			end
			ST_FL_FIN: begin
				rd_en   = 1'b1;
				rd_addr = bi_q;
			end
			ST_FL_U1: begin
				wr_en   = with_new_q;
				wr_addr = bi_q;
				wr_data = un_new;
				rd_en   = !with_new_q;
				rd_addr = bj_q;
			end
			ST_FL_U2: begin
				wr_en   = 1'b1;
				wr_addr = bi_q;
				wr_data = union_box(a_q, rd_q);
			end
			ST_FL_U3: begin
				rd_en   = 1'b1;
				rd_addr = cnt_m1[IDX_W-1:0];
			end
			ST_FL_U4: begin
				wr_en   = 1'b1;
				wr_addr = bj_q;
			end
			ST_FL_U5: begin
				wr_en   = 1'b1;
				wr_addr = cnt_m1[IDX_W-1:0];
				wr_data = r_q;
			end
			ST_CL_CHK: begin
				wr_en   = !is_empty(clip_rd);
				wr_addr = n_q[IDX_W-1:0];
				wr_data = clip_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output word loads in the emit state, drops once taken
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= operation;
						r_q     <= '{x: rect_x, y: rect_y, w: rect_w, h: rect_h};
						i_q     <= '0;
						n_q     <= '0;
						bb_q    <= '0;
						eb_q    <= '0;
						el_q    <= 1'b1;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					case (op_q)
						OP_ADD:   state_q <= is_empty(r_q) ? ST_EMIT : ST_COV_RD;
						OP_CLEAR: begin
							cnt_q   <= '0;
							state_q <= ST_EMIT;
						end
						OP_CLIP:  state_q <= ST_CL_RD;
						OP_BBOX:  state_q <= ST_BB_RD;
						OP_LIST:  state_q <= (cnt_q == '0) ? ST_EMIT : ST_LS_RD;
						default:  state_q <= ST_EMIT;
					endcase
				end
				ST_EMIT: begin
					if (out_free) begin
						out_box_q   <= eb_q;
						out_total_q <= 4'(cnt_q);
						out_last_q  <= el_q;
						state_q     <= el_q ? ST_IDLE : ST_LS_RD;
					end
				end
				// drop newcomer if some entry covers it
				ST_COV_RD: begin
					if (i_q == cnt_q) begin
						i_q     <= '0;
						state_q <= ST_RM_RD;
					end else begin
						state_q <= ST_COV_CHK;
					end
				end
				ST_COV_CHK: begin
					if (covers(rd_q, r_q)) begin
						state_q <= ST_EMIT;
					end else begin
						i_q     <= i_nxt;
						state_q <= ST_COV_RD;
					end
				end
				// remove entries the newcomer covers
				ST_RM_RD: begin
					if (i_q == cnt_q) begin
						i_q     <= '0;
						state_q <= ST_MG_RD;
					end else begin
						state_q <= ST_RM_CHK;
					end
				end
				ST_RM_CHK: begin
					if (covers(r_q, rd_q)) begin
						state_q <= ST_RM_MOVE;
					end else begin
						i_q     <= i_nxt;
						state_q <= ST_RM_RD;
					end
				end
				ST_RM_MOVE: begin
					cnt_q   <= cnt_m1;
					state_q <= ST_RM_RD;
				end
				// lossless merge search
				ST_MG_RD: state_q <= (i_q == cnt_q) ? ST_APPEND : ST_MG_LD;
				ST_MG_LD: begin
					a_q     <= rd_q;
					b_q     <= r_q;
					ret_q   <= ST_MG_CHK;
					state_q <= ST_W_PREP;
				end
				ST_MG_CHK: begin
					if (acc_q <= 33'sd0) begin
						r_q     <= union_box(a_q, r_q);
						state_q <= ST_MG_MOVE;
					end else begin
						i_q     <= i_nxt;
						state_q <= ST_MG_RD;
					end
				end
				ST_MG_MOVE: begin
					cnt_q   <= cnt_m1;
					i_q     <= '0;
					state_q <= ST_COV_RD;
				end
				ST_APPEND: begin
					if (cnt_q < CNT_W'(MAX_ENTRIES)) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_EMIT;
					end else begin
						best_q     <= BEST_INIT;
						bi_q       <= '0;
						bj_q       <= '0;
						with_new_q <= 1'b1;
						i_q        <= '0;
						state_q    <= ST_FL_RD_I;
					end
				end
				// full table: least-waste pair over all pairs and the newcomer
				ST_FL_RD_I: state_q <= (i_q == cnt_q) ? ST_FL_FIN : ST_FL_LD_I;
				ST_FL_LD_I: begin
					a_q     <= rd_q;
					b_q     <= r_q;
					ret_q   <= ST_FL_CHK_N;
					state_q <= ST_W_PREP;
				end
				ST_FL_CHK_N: begin
					if (acc_q < best_q) begin
						best_q     <= acc_q;
						bi_q       <= i_q[IDX_W-1:0];
						with_new_q <= 1'b1;
					end
					j_q     <= i_nxt;
					state_q <= ST_FL_RD_J;
				end
				ST_FL_RD_J: begin
					if (j_q == cnt_q) begin
						i_q     <= i_nxt;
						state_q <= ST_FL_RD_I;
					end else begin
						state_q <= ST_FL_LD_J;
					end
				end
				ST_FL_LD_J: begin
					b_q     <= rd_q;
					ret_q   <= ST_FL_CHK_P;
					state_q <= ST_W_PREP;
				end
				ST_FL_CHK_P: begin
					if (acc_q < best_q) begin
						best_q     <= acc_q;
						bi_q       <= i_q[IDX_W-1:0];
						bj_q       <= j_q[IDX_W-1:0];
						with_new_q <= 1'b0;
					end
					j_q     <= j_nxt;
					state_q <= ST_FL_RD_J;
				end
				ST_FL_FIN: state_q <= ST_FL_U1;
				ST_FL_U1: begin
					a_q     <= rd_q;
					state_q <= with_new_q ? ST_EMIT : ST_FL_U2;
				end
				ST_FL_U2: state_q <= ST_FL_U3;
				ST_FL_U3: state_q <= ST_FL_U4;
				ST_FL_U4: state_q <= ST_FL_U5;
				ST_FL_U5: state_q <= ST_EMIT;
				// waste = area(union) - area(a) - area(b) + area(overlap)
				ST_W_PREP: begin
					u_q     <= union_box(a_q, b_q);
					c_q     <= clip_box(a_q, b_q);
					k_q     <= 2'd0;
					acc_q   <= '0;
					state_q <= ST_W_MUL;
				end
				ST_W_MUL: begin
					prod_q <= area_sel;
					k_q    <= k_q + 2'd1;
					case (k_q)
						2'd1:    acc_q <= acc_q + $signed(33'(prod_q));
						2'd2:    acc_q <= acc_q - $signed(33'(prod_q));
						2'd3:    acc_q <= acc_q - $signed(33'(prod_q));
						default: ;
					endcase
					if (k_q == 2'd3) state_q <= ST_W_ACC;
				end
				ST_W_ACC: begin
					acc_q   <= acc_q + $signed(33'(prod_q));
					state_q <= ret_q;
				end
				// clip and compact
				ST_CL_RD: begin
					if (i_q == cnt_q) begin
						cnt_q   <= n_q;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CL_CHK;
					end
				end
				ST_CL_CHK: begin
					if (!is_empty(clip_rd)) n_q <= n_q + CNT_W'(1);
					i_q     <= i_nxt;
					state_q <= ST_CL_RD;
				end
				// bounding box
				ST_BB_RD: begin
					if (i_q == cnt_q) begin
						eb_q    <= bb_q;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_BB_CHK;
					end
				end
				ST_BB_CHK: begin
					bb_q    <= union_box(bb_q, rd_q);
					i_q     <= i_nxt;
					state_q <= ST_BB_RD;
				end
				// readout, one word per entry
				ST_LS_RD: state_q <= ST_LS_LD;
				ST_LS_LD: begin
					eb_q    <= rd_q;
					el_q    <= (i_nxt == cnt_q);
					i_q     <= i_nxt;
					state_q <= ST_EMIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign out_x       = out_box_q.x;
	assign out_y       = out_box_q.y;
	assign out_w       = out_box_q.w;
	assign out_h       = out_box_q.h;
	assign entry_total = out_total_q;
	assign last_result = out_last_q;

`include "damage_rectangle_tracker_unit_macros.svh"

	`DRT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_ENTRIES), "entry count above table depth")
	`DRT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_q != ST_IDLE, "idle after accept")
	`DRT_ASSERT_NOW(a_wr_in_range, wr_en, CNT_W'(wr_addr) <= cnt_q, "table write beyond count")
	`DRT_ASSERT_NOW(a_emit_busy, state_q == ST_EMIT, ret_q != ST_EMIT && ret_q != ST_W_MUL, "bad return state")

endmodule

// ===== tb/damage_rectangle_tracker_unit_test.sv =====
// ----------------------------------------------------------------------------
// damage_rectangle_tracker_unit_test
// drives add, clear, clip, bounding box, list and unknown words into the
// tracker with random idling on both sides; a scoreboard class keeps its own
// rectangle list, predicts every result word and checks them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module damage_rectangle_tracker_unit_test;
	import drt_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_WORDS = 380;

	typedef struct {
		int x;
		int y;
		int w;
		int h;
	} rect_t;

	typedef struct {
		int       x;
		int       y;
		int       w;
		int       h;
		bit [3:0] total;
		bit       last;
	} result_t;

	// keeps the damage list and the queue of result words still due
	class damage_scoreboard;
		rect_t   held [MAX_ENTRIES];
		int      held_count;
		result_t due [$];
		int      mismatches;
		int      words_checked;

		function new();
			held_count = 0;
			mismatches = 0;
			words_checked = 0;
		endfunction

		function int sat(int v);
			if (v < -32768) return -32768;
			if (v > 32767) return 32767;
			return v;
		endfunction

		function bit empty_r(rect_t r);
			return r.w <= 0 || r.h <= 0;
		endfunction

		function rect_t no_rect();
			rect_t z;
			z.x = 0; z.y = 0; z.w = 0; z.h = 0;
			return z;
		endfunction

		function rect_t span(int x1, int y1, int x2, int y2);
			rect_t r;
			r.x = sat(x1); r.y = sat(y1);
			r.w = sat(x2 - x1); r.h = sat(y2 - y1);
			return r;
		endfunction

		function longint area(rect_t r);
			if (empty_r(r)) return 0;
			return longint'(r.w) * longint'(r.h);
		endfunction

		function bit holds(rect_t a, rect_t b);
			if (empty_r(b)) return 1;
			if (empty_r(a)) return 0;
			return b.x >= a.x && b.y >= a.y && b.x + b.w <= a.x + a.w &&
				b.y + b.h <= a.y + a.h;
		endfunction

		function rect_t overlap(rect_t a, rect_t b);
			int x1, y1, x2, y2;
			if (empty_r(a) || empty_r(b)) return no_rect();
			x1 = a.x > b.x ? a.x : b.x;
			y1 = a.y > b.y ? a.y : b.y;
			x2 = (a.x + a.w) < (b.x + b.w) ? a.x + a.w : b.x + b.w;
			y2 = (a.y + a.h) < (b.y + b.h) ? a.y + a.h : b.y + b.h;
			if (x2 <= x1 || y2 <= y1) return no_rect();
			return span(x1, y1, x2, y2);
		endfunction

		function rect_t hull(rect_t a, rect_t b);
			if (empty_r(a)) return empty_r(b) ? no_rect() : b;
			if (empty_r(b)) return a;
			return span(a.x < b.x ? a.x : b.x, a.y < b.y ? a.y : b.y,
				(a.x + a.w) > (b.x + b.w) ? a.x + a.w : b.x + b.w,
				(a.y + a.h) > (b.y + b.h) ? a.y + a.h : b.y + b.h);
		endfunction

		function longint extra_pixels(rect_t a, rect_t b);
			return area(hull(a, b)) - (area(a) + area(b) - area(overlap(a, b)));
		endfunction

		function void add_damage(rect_t r);
			bit     merged;
			int     i, j, bi, bj;
			longint best, wv;
			bit     with_new;
			if (empty_r(r)) return;
			forever begin
				merged = 0;
				for (i = 0; i < held_count; i++)
					if (holds(held[i], r)) return;
				i = 0;
				while (i < held_count) begin
					if (holds(r, held[i])) begin
						held[i] = held[held_count - 1];
						held_count--;
					end else
						i++;
				end
				for (i = 0; i < held_count; i++) begin
					if (extra_pixels(held[i], r) <= 0) begin
						rect_t b;
						b = hull(held[i], r);
						held[i] = held[held_count - 1];
						held_count--;
						r = b;
						merged = 1;
						break;
					end
				end
				if (!merged) break;
			end
			if (held_count < MAX_ENTRIES) begin
				held[held_count++] = r;
				return;
			end
			// full list: merge the cheapest pair, the newcomer included
			best = 2147483647;
			bi = 0; bj = 0; with_new = 1;
			for (i = 0; i < held_count; i++) begin
				wv = extra_pixels(held[i], r);
				if (wv < best) begin best = wv; bi = i; with_new = 1; end
				for (j = i + 1; j < held_count; j++) begin
					wv = extra_pixels(held[i], held[j]);
					if (wv < best) begin best = wv; bi = i; bj = j; with_new = 0; end
				end
			end
			if (with_new) begin
				held[bi] = hull(held[bi], r);
				return;
			end
			held[bi] = hull(held[bi], held[bj]);
			held[bj] = held[held_count - 1];
			held[held_count - 1] = r;
		endfunction

		function void push_word(rect_t r, bit last);
			result_t e;
			e.x = r.x; e.y = r.y; e.w = r.w; e.h = r.h;
			e.total = held_count[3:0];
			e.last = last;
			due.push_back(e);
		endfunction

		function void note_word(logic [2:0] op, rect_t r);
			int    i, n;
			rect_t c, b;
			case (op)
				OP_ADD: add_damage(r);
				OP_CLEAR: held_count = 0;
				OP_CLIP: begin
					n = 0;
					for (i = 0; i < held_count; i++) begin
						c = overlap(held[i], r);
						if (!empty_r(c)) held[n++] = c;
					end
					held_count = n;
				end
				OP_BBOX: begin
					b = no_rect();
					for (i = 0; i < held_count; i++) b = hull(b, held[i]);
					push_word(b, 1);
					return;
				end
				OP_LIST: begin
					if (held_count != 0) begin
						for (i = 0; i < held_count; i++)
							push_word(held[i], i + 1 == held_count);
						return;
					end
				end
				default: ;
			endcase
			push_word(no_rect(), 1);
		endfunction

		function void check_word(result_t got);
			result_t e;
			words_checked++;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word x=%0d y=%0d w=%0d h=%0d",
						got.x, got.y, got.w, got.h);
				return;
			end
			e = due.pop_front();
			if (e.x != got.x || e.y != got.y || e.w != got.w || e.h != got.h ||
				e.total != got.total || e.last != got.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp %0d %0d %0d %0d n=%0d l=%0d got %0d %0d %0d %0d n=%0d l=%0d",
						e.x, e.y, e.w, e.h, e.total, e.last,
						got.x, got.y, got.w, got.h, got.total, got.last);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         operation;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic signed [15:0] rect_w;
	logic signed [15:0] rect_h;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_w;
	logic signed [15:0] out_h;
	logic [3:0]         entry_total;
	logic               last_result;

	damage_scoreboard sb;
	int  cycle_count;
	int  words_sent;
	int  add_words;

	damage_rectangle_tracker_unit u_top (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function int pick_gap();
		// at least a quarter of the words go back to back
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 12);
	endfunction

	// one word: idle gap, then hold it until taken
	task send_word(logic [2:0] op, int x, int y, int w, int h);
		int   gap;
		rect_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation <= op;
		rect_x <= 16'(x);
		rect_y <= 16'(y);
		rect_w <= 16'(w);
		rect_h <= 16'(h);
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		r.x = $signed(16'(x)); r.y = $signed(16'(y));
		r.w = $signed(16'(w)); r.h = $signed(16'(h));
		sb.note_word(op, r);
		words_sent++;
		if (op == OP_ADD) add_words++;
		@(negedge clk);
	endtask

	// random add inside a small field so merges and a full list come often
	task send_small_add();
		send_word(OP_ADD, $urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
			$urandom_range(1, 24), $urandom_range(1, 24));
	endtask

	task send_random_word();
		int  sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) send_small_add();
		else if (sel < 66)
			// any bit pattern at all, saturation and empty cases included
			send_word(OP_ADD, $urandom, $urandom, $urandom, $urandom);
		else if (sel < 76) send_word(OP_LIST, $urandom, $urandom, $urandom, $urandom);
		else if (sel < 85) send_word(OP_BBOX, $urandom, $urandom, $urandom, $urandom);
		else if (sel < 92)
			send_word(OP_CLIP, $urandom_range(0, 40) - 40, $urandom_range(0, 40) - 40,
				$urandom_range(0, 80), $urandom_range(0, 80));
		else if (sel < 95) send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
		else if (sel < 97) send_word(3'($urandom_range(5, 7)), $urandom, $urandom, 5, 5);
		else send_word(OP_CLIP, $urandom, $urandom, $urandom, $urandom);
	endtask

	// receiver: random stall per result word, checked at the taking edge
	initial begin
		result_t got;
		int      hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			forever begin
				@(posedge clk);
				if (out_valid) break;
			end
			got.x = out_x; got.y = out_y; got.w = out_w; got.h = out_h;
			got.total = entry_total;
			got.last = last_result;
			sb.check_word(got);
			@(negedge clk);
		end
	end

	initial begin
		int i;
		sb = new();
		cycle_count = 0;
		words_sent = 0;
		add_words = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_CLEAR;
		rect_x = '0;
		rect_y = '0;
		rect_w = '0;
		rect_h = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty list readout, empty adds, extremes, every code
		send_word(OP_LIST, 0, 0, 0, 0);
		send_word(OP_BBOX, 0, 0, 0, 0);
		send_word(OP_ADD, 5, 5, 0, 10);
		send_word(OP_ADD, 5, 5, 10, -32768);
		send_word(OP_ADD, 0, 0, 10, 10);
		send_word(OP_ADD, 2, 2, 3, 3);
		send_word(OP_ADD, 10, 0, 10, 10);
		send_word(OP_ADD, -5, -5, 40, 40);
		send_word(OP_ADD, 32767, 32767, 32767, 32767);
		send_word(OP_ADD, -32768, -32768, 32767, 32767);
		send_word(OP_BBOX, 0, 0, 0, 0);
		send_word(OP_LIST, 0, 0, 0, 0);
		send_word(OP_CLIP, -100, -100, 200, 200);
		send_word(OP_LIST, 0, 0, 0, 0);
		for (i = 0; i < 9; i++) send_word(OP_ADD, i * 30, (i % 3) * 40, 7, 9);
		send_word(OP_LIST, 0, 0, 0, 0);
		send_word(OP_CLIP, 0, 0, -1, 50);
		send_word(OP_ADD, 1, 1, 1, 1);
		send_word(OP_CLEAR, 0, 0, 0, 0);
		send_word(3'd5, 1, 2, 3, 4);
		send_word(3'd6, -1, -1, -1, -1);
		send_word(3'd7, 0, 0, 0, 0);

		for (i = 0; i < RANDOM_WORDS; i++) send_random_word();
		send_word(OP_LIST, 0, 0, 0, 0);
		in_valid <= 1'b0;

		while (sb.due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		$display("sent %0d words (%0d adds) and checked %0d result words",
			words_sent, add_words, sb.words_checked);
		$display("%0d mismatches, %0d result words still due",
			sb.mismatches, sb.due.size());
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== damage_rectangle_tracker_unit.f =====
+incdir+design
design/drt_pkg.sv
design/damage_rectangle_tracker_unit.sv
tb/damage_rectangle_tracker_unit_test.sv
